/* hdl/cspb_pkg.sv */
// cspb_pkg: shared types and constants for the capture span builder
`default_nettype none
package cspb_pkg;

    localparam int MARKER_W     = 32;
    localparam int POS_W        = 32;
    localparam int VAR_IDX_W    = 4;
    // two marker bits per variable, so the marker word carries at most this many
    localparam int MAX_VARS     = MARKER_W / 2;
    localparam int NUM_VARS_DEF = 16;

    typedef struct packed {
        logic                starts_mapping;
        logic [MARKER_W-1:0] marker_bits;
        logic [POS_W-1:0]    doc_position;
    } t_in_word;

    typedef struct packed {
        logic [VAR_IDX_W-1:0] var_index;
        logic [POS_W-1:0]     span_start;
        logic [POS_W-1:0]     span_end;
        logic                 last_of_run;
    } t_out_word;

endpackage
`default_nettype wire

/* hdl/cspb_ram.sv */
// cspb_ram: generic simple dual-port ram, registered read, read-first
`default_nettype none
module cspb_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // same-address read returns the old contents
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

/* hdl/capture_span_builder_top.sv */
// capture_span_builder_top: turns open/close marker annotations into capture spans
//
// input channel: one annotation word per handshake (i_valid / o_stall), in ascending
// position order. output channel: one span word per handshake (o_valid / i_stall).
// an annotation is scanned one variable per cycle unless a stall holds it, highest
// variable first, visiting only variables it opens or closes-while-pending. the next
// annotation is taken once the scan is done. span starts live in a small ram with a
// registered read; the read data register is the output register, so a span word is
// shown from the register after the scan visits its closing variable, and the first
// span of an annotation waits behind any open-only variables above it; later spans
// follow as the scan visits each further closing variable.
// pending flags sit in flip-flops and are cleared by reset, so no ram clearing pass
// is needed. while the receiver stalls, the shown span holds and the scan pauses at
// the next span-producing variable (open-only variables keep going).
// reset (synchronous, active low) drops any scan in progress and any shown span.
`default_nettype none
module capture_span_builder_top #(
    parameter int NUM_VARS = cspb_pkg::NUM_VARS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire cspb_pkg::t_in_word  i_in_word,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output cspb_pkg::t_out_word      o_out_word
);
    import cspb_pkg::*;

    // only variables whose two marker bits fit in the marker word take part
    localparam int NV = (NUM_VARS > MAX_VARS) ? MAX_VARS : NUM_VARS;
    localparam int AW = (NV > 1) ? $clog2(NV) : 1;

    logic           r_busy,    n_busy;
    logic [NV-1:0]  r_opens,   n_opens;
    logic [NV-1:0]  r_closes,  n_closes;
    logic [NV-1:0]  r_pending, n_pending;
    logic [POS_W-1:0] r_pos,   n_pos;
    logic           r_s2_valid, n_s2_valid;
    logic [AW-1:0]  r_s2_var,  n_s2_var;
    logic [POS_W-1:0] r_s2_end, n_s2_end;
    logic           r_s2_last, n_s2_last;

    logic           in_acc;
    logic [NV-1:0]  emit_mask;
    logic [NV-1:0]  work_mask;
    logic [NV-1:0]  sel_onehot;
    logic [NV-1:0]  lower_mask;
    logic [AW-1:0]  sel;
    logic           any_work;
    logic           sel_emit;
    logic           sel_open;
    logic           slot_free;
    logic           step;
    logic           sel_last;
    logic           scan_done;
    logic [NV-1:0]  in_opens;
    logic [NV-1:0]  in_closes;
    logic [POS_W-1:0] rd_data;

    assign in_acc = i_valid && !o_stall;

    always_comb begin
        for (int v = 0; v < NV; v++) begin
            in_opens[v]  = i_in_word.marker_bits[2*v];
            in_closes[v] = i_in_word.marker_bits[2*v+1];
        end
    end

    assign emit_mask = r_closes & r_pending;
    assign work_mask = r_opens | emit_mask;
    assign any_work  = |work_mask;

    // highest variable with something to do
    always_comb begin
        sel = '0;
        for (int v = 0; v < NV; v++) begin
            if (work_mask[v]) begin
                sel = AW'(v);
            end
        end
    end

    always_comb begin
        for (int v = 0; v < NV; v++) begin
            sel_onehot[v] = (AW'(v) == sel);
            lower_mask[v] = (AW'(v) < sel);
        end
    end

    assign sel_emit  = |(emit_mask & sel_onehot);
    assign sel_open  = |(r_opens & sel_onehot);
    assign slot_free = !r_s2_valid || !i_stall;
    assign step      = r_busy && any_work && (!sel_emit || slot_free);
    assign sel_last  = ~|(emit_mask & lower_mask);
    assign scan_done = r_busy && (!any_work || (step && ~|(work_mask & ~sel_onehot)));

    always_comb begin
        n_busy     = r_busy;
        n_opens    = r_opens;
        n_closes   = r_closes;
        n_pending  = r_pending;
        n_pos      = r_pos;
        n_s2_valid = r_s2_valid;
        n_s2_var   = r_s2_var;
        n_s2_end   = r_s2_end;
        n_s2_last  = r_s2_last;

        if (in_acc) begin
            n_busy   = 1'b1;
            n_opens  = in_opens;
            n_closes = in_closes;
            n_pos    = i_in_word.doc_position;
            if (i_in_word.starts_mapping) begin
                n_pending = '0;
            end
        end

        if (step) begin
            n_opens  = r_opens & ~sel_onehot;
            n_closes = r_closes & ~sel_onehot;
            // close is handled first, then an open sets pending again
            n_pending = sel_open ? (r_pending | sel_onehot) : (r_pending & ~sel_onehot);
        end

        if (scan_done) begin
            n_busy = 1'b0;
        end

        if (step && sel_emit) begin
            n_s2_valid = 1'b1;
            n_s2_var   = sel;
            n_s2_end   = r_pos;
            n_s2_last  = sel_last;
        end else if (r_s2_valid && !i_stall) begin
            n_s2_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_pending  <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_pending  <= n_pending;
            r_s2_valid <= n_s2_valid;
        end
        r_opens   <= n_opens;
        r_closes  <= n_closes;
        r_pos     <= n_pos;
        r_s2_var  <= n_s2_var;
        r_s2_end  <= n_s2_end;
        r_s2_last <= n_s2_last;
    end

    cspb_ram #(
        .WIDTH  (POS_W),
        .DEPTH  (NV),
        .ADDR_W (AW)
    ) u_start_ram (
        .i_clk     (i_clk),
        .i_wr_en   (step && sel_open),
        .i_wr_addr (sel),
        .i_wr_data (r_pos),
        .i_rd_en   (step && sel_emit),
        .i_rd_addr (sel),
        .o_rd_data (rd_data)
    );

    assign o_stall                = r_busy;
    assign o_valid                = r_s2_valid;
    assign o_out_word.var_index   = VAR_IDX_W'(r_s2_var);
    assign o_out_word.span_start  = rd_data;
    assign o_out_word.span_end    = r_s2_end;
    assign o_out_word.last_of_run = r_s2_last;

    a_span_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_s2_valid) |-> $past(r_busy))
        else $error("span word appeared without an active scan");

    a_mapping_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.starts_mapping) |=> (r_pending == '0))
        else $error("pending flags survived a new mapping");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !any_work) |=> !r_busy)
        else $error("scan did not finish with no work left");

endmodule
`default_nettype wire
